// ===== rtl/core/lec_pkg.sv =====
`timescale 1ns / 1ps

package lec_pkg;

  // Byte codes used for classification
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_FF    = 8'h0C;

  // Text test: printable >> BIN_SHIFT must reach nonprintable
  localparam int unsigned BIN_SHIFT = 7;

  // Request types
  localparam logic REQ_ANALYSE = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  // Direction and policy codes
  localparam logic DIR_CHECKIN  = 1'b0;
  localparam logic POLICY_FORCE = 1'b1;
  localparam logic [1:0] AUTO_OFF  = 2'b00;
  localparam logic [1:0] AUTO_BOTH = 2'b01;

  // Result kinds
  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_DECISION = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO      = 2'd2;

  // Result queue geometry
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned USED_W     = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last;
  } lec_in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic       out_last;
    logic       converted;
  } lec_out_t;

  // Results of one item: count and up to two entries, r0 first
  typedef struct packed {
    logic [1:0] n;
    lec_out_t   r0;
    lec_out_t   r1;
  } lec_push_t;

  typedef struct packed {
    logic [USED_W-1:0] used;
    logic [USED_W-1:0] free;
  } lec_fifo_stat_t;

endpackage

// ===== rtl/core/line_ending_converter.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_data_i  (lec_in_t)
// out       output     out_valid_o / out_ready_i  out_data_o (lec_out_t)
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One item per cycle while the result queue has room; an item is held in the input
// register, and from there its results are written into the result queue ahead of the output.
// A CR inserted before a lone LF makes two results, so the two-entry result
// queue can hold back the input when the output drains one per cycle.
// Reset clears the configuration, counters, line state, decision and queue.
// Either side may stall at any time; nothing is lost or repeated.

module line_ending_converter #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lec_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lec_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  lec_pkg::lec_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output lec_pkg::lec_out_t                out_data_o
);
  import lec_pkg::*;

  lec_in_t        in_q;
  logic           in_valid_q;
  logic           fire;
  lec_push_t      push;
  lec_fifo_stat_t stat;

  // Process the held item once its results fit in the queue
  assign fire       = in_valid_q && (USED_W'(push.n) <= stat.free);
  assign in_ready_o = !in_valid_q || fire;

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  lec_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (in_q),
    .fire_i     (fire),
    .push_o     (push)
  );

  lec_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_en_i  (fire),
    .push_i     (push),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .stat_o     (stat)
  );

  // Queue never exceeds its depth
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.used <= USED_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // Two results only for an inserted CR ahead of the byte
  a_insert_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (push.n == 2'd2)) |->
      (push.r0.out_byte == CH_CR) && !push.r0.out_last && (push.r1.out_byte == CH_LF))
    else $error("double result is not a CR insertion");

  // A held item that cannot go stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !fire) |=> in_valid_q && $stable(in_q))
    else $error("held item lost");

  // Only defined kinds leave the block
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.result_kind == KIND_DATA) ||
                    (out_data_o.result_kind == KIND_DECISION) ||
                    (out_data_o.result_kind == KIND_END))
    else $error("undefined result kind");

endmodule

// ===== rtl/core/lec_step.sv =====
`timescale 1ns / 1ps

module lec_step #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lec_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lec_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  lec_pkg::lec_in_t                 item_i,
  input  logic                             fire_i,
  output lec_pkg::lec_push_t               push_o
);
  import lec_pkg::*;

  logic                   direction_q, policy_q;
  logic [1:0]             auto_q;
  logic                   prev_cr_q, decision_q;
  logic [COUNT_WIDTH-1:0] cr_q, lf_q, crlf_q, pr_q, np_q;
  logic [COUNT_WIDTH-1:0] cr_d, lf_d, crlf_d, pr_d, np_d;

  logic is_cr, is_lf, is_ctl_print, is_nonprint, is_print;
  logic binary, decide_d;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  // Classify the byte
  assign is_cr        = (item_i.data_byte == CH_CR);
  assign is_lf        = (item_i.data_byte == CH_LF);
  assign is_ctl_print = (item_i.data_byte == CH_BS)  || (item_i.data_byte == CH_HT) ||
                        (item_i.data_byte == CH_ESC) || (item_i.data_byte == CH_FF);
  assign is_nonprint  = (item_i.data_byte == CH_DEL) ||
                        ((item_i.data_byte < CH_SPACE) && !is_cr && !is_lf && !is_ctl_print);
  assign is_print     = !is_cr && !is_lf && !is_nonprint;

  // Counters including this byte
  assign cr_d   = is_cr ? sat_inc(cr_q) : cr_q;
  assign lf_d   = is_lf ? sat_inc(lf_q) : lf_q;
  assign crlf_d = (is_lf && prev_cr_q) ? sat_inc(crlf_q) : crlf_q;
  assign pr_d   = is_print ? sat_inc(pr_q) : pr_q;
  assign np_d   = is_nonprint ? sat_inc(np_q) : np_q;

  // Decide on the counts that include the last byte
  assign binary = (pr_d >> BIN_SHIFT) < np_d;

  always_comb begin
    if (policy_q == POLICY_FORCE) begin
      decide_d = 1'b1;
    end else if (direction_q == DIR_CHECKIN) begin
      decide_d = (auto_q != AUTO_OFF) && (cr_d != '0) && (cr_d == crlf_d) && !binary;
    end else begin
      decide_d = (auto_q == AUTO_BOTH) && (lf_d != '0) && (lf_d != crlf_d) &&
                 (cr_d == crlf_d) && !binary;
    end
  end

  // Build the results of this item
  always_comb begin
    push_o = '0;
    if (item_i.req_type == REQ_ANALYSE) begin
      if (item_i.last) begin
        push_o.n  = 2'd1;
        push_o.r0 = '{result_kind: KIND_DECISION, out_byte: 8'h00, out_last: 1'b1,
                      converted: decide_d};
      end
    end else if (!decision_q) begin
      push_o.n  = 2'd1;
      push_o.r0 = '{result_kind: KIND_DATA, out_byte: item_i.data_byte,
                    out_last: item_i.last, converted: decision_q};
    end else if (direction_q == DIR_CHECKIN) begin
      if (!is_cr) begin
        push_o.n  = 2'd1;
        push_o.r0 = '{result_kind: KIND_DATA, out_byte: item_i.data_byte,
                      out_last: item_i.last, converted: decision_q};
      end else if (item_i.last) begin
        push_o.n  = 2'd1;
        push_o.r0 = '{result_kind: KIND_END, out_byte: 8'h00, out_last: 1'b1,
                      converted: decision_q};
      end
    end else if (is_lf && !prev_cr_q) begin
      push_o.n  = 2'd2;
      push_o.r0 = '{result_kind: KIND_DATA, out_byte: CH_CR, out_last: 1'b0,
                    converted: decision_q};
      push_o.r1 = '{result_kind: KIND_DATA, out_byte: item_i.data_byte,
                    out_last: item_i.last, converted: decision_q};
    end else begin
      push_o.n  = 2'd1;
      push_o.r0 = '{result_kind: KIND_DATA, out_byte: item_i.data_byte,
                    out_last: item_i.last, converted: decision_q};
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
      policy_q    <= 1'b0;
      auto_q      <= AUTO_OFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DIRECTION: direction_q <= cfg_wdata_i[0];
        REG_POLICY:    policy_q    <= cfg_wdata_i[0];
        REG_AUTO:      auto_q      <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Advance counters, line state and decision
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cr_q  <= 1'b0;
      decision_q <= 1'b0;
      cr_q       <= '0;
      lf_q       <= '0;
      crlf_q     <= '0;
      pr_q       <= '0;
      np_q       <= '0;
    end else if (fire_i) begin
      prev_cr_q <= is_cr && !item_i.last;
      if (item_i.req_type == REQ_ANALYSE) begin
        if (item_i.last) begin
          decision_q <= decide_d;
          cr_q       <= '0;
          lf_q       <= '0;
          crlf_q     <= '0;
          pr_q       <= '0;
          np_q       <= '0;
        end else begin
          cr_q   <= cr_d;
          lf_q   <= lf_d;
          crlf_q <= crlf_d;
          pr_q   <= pr_d;
          np_q   <= np_d;
        end
      end
    end
  end

endmodule

// ===== rtl/core/lec_out_fifo.sv =====
`timescale 1ns / 1ps

module lec_out_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_en_i,
  input  lec_pkg::lec_push_t      push_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output lec_pkg::lec_out_t       out_data_o,
  output lec_pkg::lec_fifo_stat_t stat_o
);
  import lec_pkg::*;

  lec_out_t          mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wp_q, rp_q;
  logic [USED_W-1:0] used_q, used_d, n_push;
  logic              pop;

  assign out_valid_o = (used_q != '0);
  assign out_data_o  = mem_q[rp_q];
  assign pop         = out_valid_o && out_ready_i;
  assign n_push      = push_en_i ? USED_W'(push_i.n) : '0;
  assign used_d      = used_q + n_push - USED_W'(pop);

  // Room for the next item counts the entry leaving this cycle
  assign stat_o.used = used_q;
  assign stat_o.free = USED_W'(FIFO_DEPTH) - used_q + USED_W'(pop);

  // Write up to two entries, r0 first
  always_ff @(posedge clk_i) begin
    if (push_en_i && (push_i.n != 2'd0)) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_en_i && (push_i.n == 2'd2)) begin
      mem_q[wp_q + PTR_W'(1)] <= push_i.r1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      used_q <= '0;
    end else begin
      wp_q   <= wp_q + n_push[PTR_W-1:0];
      rp_q   <= rp_q + PTR_W'(pop);
      used_q <= used_d;
    end
  end

endmodule
